// ----- hdl/wsp_pkg.sv -----
package wsp_pkg;

  // Chunk identifiers, first byte in the top byte
  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666D_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;

  // Fixed part of the format chunk body that is read
  localparam logic [31:0] FMT_BODY = 32'd16;

  localparam logic [15:0] SEARCH_WINDOW_RESET = 16'd512;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_RIFF  = 3'd0;
  localparam logic [2:0] ERR_WAVE  = 3'd1;
  localparam logic [2:0] ERR_FMT   = 3'd2;
  localparam logic [2:0] ERR_DATA  = 3'd3;
  localparam logic [2:0] ERR_WIDTH = 3'd4;

  // One byte of the file with its start-of-file mark
  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } item_t;

  // Front to queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  // Queue to back
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ----- hdl/wav_stream_parser.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_ready    byte_value, file_start
// out      out_valid / out_ready  kind, channels, rate_hz, sample_bits,
//                                 total_samples, sample, last_sample, error_code
// cfg      cfg_valid / cfg_ready  search_window
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through the input stage, the queue and the result register.
// The byte interpreter handles one queued byte a cycle whenever the result
// register is empty or being taken; cfg_ready is always high.
// Reset clears the parse state and loads the search window register with 512.
// A stalled output fills the queue, then the input stage, then drops in_ready.
module wav_stream_parser
  import wsp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_value,
  input  logic               file_start,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        search_window,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [15:0]        channels,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits,
  output logic [30:0]        total_samples,
  output logic signed [31:0] sample,
  output logic               last_sample,
  output logic [2:0]         error_code
);

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  wsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .file_start (file_start),
    .q_full     (q_full),
    .push       (push)
  );

  wsp_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .pop  (pop),
    .head (head)
  );

  wsp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .search_window (search_window),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .channels      (channels),
    .rate_hz       (rate_hz),
    .sample_bits   (sample_bits),
    .total_samples (total_samples),
    .sample        (sample),
    .last_sample   (last_sample),
    .error_code    (error_code)
  );

endmodule

// ----- hdl/wsp_front.sv -----
module wsp_front
  import wsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_value,
  input  logic       file_start,
  input  logic       q_full,
  output push_t      push
);

  logic  stage_valid;
  item_t stage_item;

  // Stage empties whenever the queue has room, so a byte can enter every cycle
  assign in_ready = !stage_valid || !q_full;

  // Input stage: latch the byte and tag the start of a file
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_item.start <= file_start;
      stage_item.data  <= byte_value;
    end
  end

  assign push.valid = stage_valid && !q_full;
  assign push.item  = stage_item;

endmodule

// ----- hdl/wsp_queue.sv -----
module wsp_queue
  import wsp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  full,
  input  logic  pop,
  output head_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_pop_moves_head: assert property (@(posedge clk) disable iff (rst)
    (pop && head.valid && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue pop lost");
`endif

endmodule

// ----- hdl/wsp_back.sv -----
module wsp_back
  import wsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        search_window,
  input  head_t              head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [15:0]        channels,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits,
  output logic [30:0]        total_samples,
  output logic signed [31:0] sample,
  output logic               last_sample,
  output logic [2:0]         error_code
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_SFMT, PH_FSIZE, PH_FBODY,
    PH_FSKIP, PH_SDATA, PH_DSIZE, PH_SAMPLE, PH_DONE, PH_ERROR
  } phase_t;

  // Parse state
  logic [15:0] window;
  phase_t      phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] match_window, match_window_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [31:0] fmt_length, fmt_length_next;
  logic [31:0] skip_length, skip_length_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_value, rate_value_next;
  logic [15:0] width_bits, width_bits_next;
  logic [31:0] samples_left, samples_left_next;
  logic        is16, is16_next;

  // Working view after a start-of-file byte has cleared the parse
  phase_t      cur_phase;
  logic [31:0] cur_count;
  logic [31:0] cur_match;
  logic [31:0] cur_word;
  logic [31:0] cnt_inc;
  logic [31:0] shifted;
  logic [31:0] word_lane;
  logic [7:0]  b;

  // Result of this byte
  logic        emit;
  logic [1:0]  res_kind;
  logic [31:0] res_sample;
  logic        res_last;
  logic [2:0]  res_error;
  logic        res_header;

  assign cfg_ready = 1'b1;
  assign pop = head.valid && (!out_valid || out_ready);

  assign b         = head.item.data;
  assign cur_phase = head.item.start ? PH_RIFF : phase;
  assign cur_count = head.item.start ? '0 : byte_count;
  assign cur_match = head.item.start ? '0 : match_window;
  assign cur_word  = head.item.start ? '0 : word_assembly;
  assign cnt_inc   = cur_count + 32'd1;
  assign shifted   = {cur_match[23:0], b};
  assign word_lane = cur_word | ({24'd0, b} << {cur_count[1:0], 3'b000});

  // Byte interpreter
  always_comb begin
    phase_next         = cur_phase;
    byte_count_next    = cur_count;
    match_window_next  = cur_match;
    word_assembly_next = cur_word;
    fmt_length_next    = fmt_length;
    skip_length_next   = skip_length;
    channel_count_next = channel_count;
    rate_value_next    = rate_value;
    width_bits_next    = width_bits;
    samples_left_next  = samples_left;
    is16_next          = is16;
    emit               = 1'b0;
    res_kind           = KIND_HEADER;
    res_sample         = '0;
    res_last           = 1'b0;
    res_error          = ERR_RIFF;
    res_header         = 1'b0;

    case (cur_phase)
      PH_RIFF, PH_WAVE: begin
        match_window_next = shifted;
        byte_count_next   = cnt_inc;
        if (cnt_inc >= 32'd4) begin
          byte_count_next = '0;
          if (cur_phase == PH_RIFF) begin
            if (shifted != ID_RIFF) begin
              emit = 1'b1; res_kind = KIND_ERROR; res_error = ERR_RIFF;
              phase_next = PH_ERROR;
            end else begin
              phase_next = PH_RSIZE;
            end
          end else begin
            if (shifted != ID_WAVE) begin
              emit = 1'b1; res_kind = KIND_ERROR; res_error = ERR_WAVE;
              phase_next = PH_ERROR;
            end else begin
              match_window_next = '0;
              phase_next = PH_SFMT;
            end
          end
        end
      end
      PH_RSIZE: begin
        byte_count_next = cnt_inc;
        if (cnt_inc >= 32'd4) begin
          byte_count_next = '0;
          phase_next = PH_WAVE;
        end
      end
      PH_SFMT, PH_SDATA: begin
        match_window_next = shifted;
        byte_count_next   = cnt_inc;
        if (cnt_inc >= 32'd4 &&
            shifted == ((cur_phase == PH_SFMT) ? ID_FMT : ID_DATA)) begin
          byte_count_next    = '0;
          word_assembly_next = '0;
          phase_next = (cur_phase == PH_SFMT) ? PH_FSIZE : PH_DSIZE;
        end else if (cnt_inc >= {16'd0, window}) begin
          emit = 1'b1; res_kind = KIND_ERROR;
          res_error = (cur_phase == PH_SFMT) ? ERR_FMT : ERR_DATA;
          phase_next = PH_ERROR;
        end
      end
      PH_FSIZE: begin
        word_assembly_next = word_lane;
        byte_count_next    = cnt_inc;
        if (cnt_inc >= 32'd4) begin
          byte_count_next    = '0;
          fmt_length_next    = word_lane;
          word_assembly_next = '0;
          channel_count_next = '0;
          rate_value_next    = '0;
          width_bits_next    = '0;
          phase_next         = PH_FBODY;
        end
      end
      PH_FBODY: begin
        // Pick out channels, rate and bits per sample
        case (cur_count[3:0])
          4'd2:    channel_count_next[7:0]  = b;
          4'd3:    channel_count_next[15:8] = b;
          4'd4:    rate_value_next[7:0]     = b;
          4'd5:    rate_value_next[15:8]    = b;
          4'd6:    rate_value_next[23:16]   = b;
          4'd7:    rate_value_next[31:24]   = b;
          4'd14:   width_bits_next[7:0]     = b;
          4'd15:   width_bits_next[15:8]    = b;
          default: ;
        endcase
        byte_count_next = cnt_inc;
        skip_length_next = fmt_length - FMT_BODY;
        if (cnt_inc >= FMT_BODY) begin
          byte_count_next   = '0;
          match_window_next = '0;
          phase_next = (fmt_length > FMT_BODY) ? PH_FSKIP : PH_SDATA;
        end
      end
      PH_FSKIP: begin
        byte_count_next = cnt_inc;
        if (cnt_inc >= skip_length) begin
          byte_count_next   = '0;
          match_window_next = '0;
          phase_next = PH_SDATA;
        end
      end
      PH_DSIZE: begin
        word_assembly_next = word_lane;
        byte_count_next    = cnt_inc;
        if (cnt_inc >= 32'd4) begin
          byte_count_next = '0;
          emit = 1'b1;
          if (width_bits[15:3] != 13'd2 && width_bits[15:3] != 13'd4) begin
            res_kind = KIND_ERROR; res_error = ERR_WIDTH;
            phase_next = PH_ERROR;
          end else begin
            is16_next = (width_bits[15:3] == 13'd2);
            samples_left_next = (width_bits[15:3] == 13'd2) ?
                                {1'b0, word_lane[31:1]} : {2'b00, word_lane[31:2]};
            word_assembly_next = '0;
            res_kind   = KIND_HEADER;
            res_header = 1'b1;
            phase_next = (samples_left_next != '0) ? PH_SAMPLE : PH_DONE;
          end
        end
      end
      PH_SAMPLE: begin
        word_assembly_next = word_lane;
        byte_count_next    = cnt_inc;
        if (cnt_inc >= (is16 ? 32'd2 : 32'd4)) begin
          res_sample = is16 ? {{16{word_lane[15]}}, word_lane[15:0]} : word_lane;
          byte_count_next    = '0;
          word_assembly_next = '0;
          samples_left_next  = samples_left - 32'd1;
          emit     = 1'b1;
          res_kind = KIND_SAMPLE;
          res_last = (samples_left_next == '0);
          if (samples_left_next == '0) begin
            phase_next = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  // Configuration register and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= SEARCH_WINDOW_RESET;
      phase         <= PH_RIFF;
      byte_count    <= '0;
      match_window  <= '0;
      word_assembly <= '0;
      fmt_length    <= '0;
      skip_length   <= '0;
      channel_count <= '0;
      rate_value    <= '0;
      width_bits    <= '0;
      samples_left  <= '0;
      is16          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window <= search_window;
      end
      if (pop) begin
        phase         <= phase_next;
        byte_count    <= byte_count_next;
        match_window  <= match_window_next;
        word_assembly <= word_assembly_next;
        fmt_length    <= fmt_length_next;
        skip_length   <= skip_length_next;
        channel_count <= channel_count_next;
        rate_value    <= rate_value_next;
        width_bits    <= width_bits_next;
        samples_left  <= samples_left_next;
        is16          <= is16_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop && emit) begin
      kind          <= res_kind;
      channels      <= res_header ? channel_count : '0;
      rate_hz       <= res_header ? rate_value : '0;
      sample_bits   <= res_header ? width_bits : '0;
      total_samples <= res_header ? samples_left_next[30:0] : '0;
      sample        <= res_sample;
      last_sample   <= res_last;
      error_code    <= (res_kind == KIND_ERROR) ? res_error : '0;
    end
  end

`ifndef ASSERT_OFF
  a_quiet_after_end: assert property (@(posedge clk) disable iff (rst)
    (pop && !head.item.start && (phase == PH_DONE || phase == PH_ERROR)) |-> !emit)
    else $error("result after end of file or error");

  a_last_ends_data: assert property (@(posedge clk) disable iff (rst)
    (pop && emit && res_kind == KIND_SAMPLE && res_last) |=> (phase == PH_DONE))
    else $error("last sample did not close the data chunk");

  a_samples_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SAMPLE) |-> (samples_left != '0))
    else $error("sample phase with no samples left");
`endif

endmodule
